/* rtl/idp_pkg.sv */
// ----------------------------------------------------------------------------
// idp_pkg
// Shared command and status codes and fixed widths for the id pool allocator.
// ----------------------------------------------------------------------------
package idp_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // command codes; code 3 has no meaning and falls to the default arm
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_ID    = 2'd3
  } status_t;

  // marker written into a table entry on remove, cut to the handle width
  localparam logic [63:0] VOID_MARKER = 64'h0000_0000_deca_fbad;

endpackage

/* rtl/id_pool_allocator.sv */
// ----------------------------------------------------------------------------
// id_pool_allocator
// Maps small integer ids to handles, keeps a lifo stack of freed ids and a
// high-water count; serves add, remove and lookup commands.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid in_ready in_command in_id in_handle | sink
//  out     | out_valid out_ready out_result_id            | source
//          | out_result_handle out_status                 |
//
// remove, add from the high-water mark, pool full, unknown command and a
// lookup at or past high water load the result register from idle; add that
// reuses a freed id and any other lookup go through S_RD first, for the read
// of the single-port free stack or handle table before the result is known.
// a new word is taken only from idle, once the result register is empty or
// being emptied in the same cycle, so memory accesses never overlap.
// reset clears the counts and the control state; both memories start
// undefined and need no clearing pass, every table read is below high water.
// a stalled out channel holds its word and blocks the next input word.
// ----------------------------------------------------------------------------
module id_pool_allocator #(
  parameter int POOL_SIZE   = 1024,
  parameter int HANDLE_BITS = 32,
  localparam int ID_BITS    = $clog2(POOL_SIZE)
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [idp_pkg::CMD_W-1:0]     in_command,
  input  logic [ID_BITS-1:0]            in_id,
  input  logic [HANDLE_BITS-1:0]        in_handle,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ID_BITS-1:0]            out_result_id,
  output logic [HANDLE_BITS-1:0]        out_result_handle,
  output logic [idp_pkg::STATUS_W-1:0]  out_status
);

  import idp_pkg::*;

  // counts must hold POOL_SIZE itself
  localparam int CNT_BITS = $clog2(POOL_SIZE + 1);

  localparam logic [CNT_BITS-1:0]    POOL_CNT = CNT_BITS'(POOL_SIZE);
  localparam logic [HANDLE_BITS-1:0] VOID_H   = HANDLE_BITS'(VOID_MARKER);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,  // waiting for an input word
    S_RD   = 2'b10   // memory read data is back, finish the command
  } state_t;

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  logic [HANDLE_BITS-1:0] tbl_mem [POOL_SIZE];
  logic [ID_BITS-1:0]     stk_mem [POOL_SIZE];

  logic [HANDLE_BITS-1:0] tbl_rdata_r;
  logic [ID_BITS-1:0]     stk_rdata_r;

  // --------------------------------------------------------------------------
  // control and bookkeeping registers
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [CNT_BITS-1:0]    free_count_r, free_count_nxt;
  logic [CNT_BITS-1:0]    high_water_r, high_water_nxt;

  // command held over the read cycle
  logic [CMD_W-1:0]       cmd_r;
  logic [ID_BITS-1:0]     id_r;
  logic [HANDLE_BITS-1:0] handle_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [ID_BITS-1:0]     res_id_r;
  logic [HANDLE_BITS-1:0] res_handle_r;
  status_t                res_status_r;

  // memory port controls
  logic                   tbl_we, tbl_re;
  logic [ID_BITS-1:0]     tbl_addr;
  logic [HANDLE_BITS-1:0] tbl_wdata;
  logic                   stk_we, stk_re;
  logic [ID_BITS-1:0]     stk_addr;
  logic [ID_BITS-1:0]     stk_wdata;

  // result load
  logic                   res_load;
  logic [ID_BITS-1:0]     res_id;
  logic [HANDLE_BITS-1:0] res_handle;
  status_t                res_status;

  logic                   in_fire;
  logic [CNT_BITS-1:0]    in_id_cnt;
  logic [CNT_BITS-1:0]    free_count_dec;

  // take a word only from idle with room in the result register
  assign in_ready       = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire        = in_valid && in_ready;
  assign in_id_cnt      = CNT_BITS'(in_id);
  assign free_count_dec = free_count_r - 1'b1;

  // --------------------------------------------------------------------------
  // command decode
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    free_count_nxt = free_count_r;
    high_water_nxt = high_water_r;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    tbl_addr       = in_id;
    tbl_wdata      = in_handle;
    stk_we         = 1'b0;
    stk_re         = 1'b0;
    stk_addr       = free_count_dec[ID_BITS-1:0];
    stk_wdata      = in_id;
    res_load       = 1'b0;
    res_id         = in_id;
    res_handle     = '0;
    res_status     = STAT_OK;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_command)
            CMD_ADD: begin
              if (free_count_r != '0) begin
                // pop the most recently freed id, table write follows
                stk_re         = 1'b1;
                stk_addr       = free_count_dec[ID_BITS-1:0];
                free_count_nxt = free_count_dec;
                state_nxt      = S_RD;
              end else if (high_water_r < POOL_CNT) begin
                tbl_we         = 1'b1;
                tbl_addr       = high_water_r[ID_BITS-1:0];
                tbl_wdata      = in_handle;
                high_water_nxt = high_water_r + 1'b1;
                res_load       = 1'b1;
                res_id         = high_water_r[ID_BITS-1:0];
              end else begin
                res_load   = 1'b1;
                res_id     = '0;
                res_status = STAT_FULL;
              end
            end
            CMD_REMOVE: begin
              res_load = 1'b1;
              if (in_id_cnt >= high_water_r) begin
                res_status = STAT_BAD_ID;
              end else if (free_count_r >= POOL_CNT) begin
                // only reachable by freeing one id over and over
                res_status = STAT_FULL;
              end else begin
                tbl_we         = 1'b1;
                tbl_addr       = in_id;
                tbl_wdata      = VOID_H;
                stk_we         = 1'b1;
                stk_addr       = free_count_r[ID_BITS-1:0];
                stk_wdata      = in_id;
                free_count_nxt = free_count_r + 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (in_id_cnt >= high_water_r) begin
                res_load   = 1'b1;
                res_status = STAT_NOT_FOUND;
              end else begin
                tbl_re    = 1'b1;
                tbl_addr  = in_id;
                state_nxt = S_RD;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = STAT_NOT_FOUND;
            end
          endcase
        end
      end
      S_RD: begin
        res_load  = 1'b1;
        res_id    = id_r;
        state_nxt = S_IDLE;
        if (cmd_r == CMD_ADD) begin
          // popped id is back, store the handle there
          tbl_we    = 1'b1;
          tbl_addr  = stk_rdata_r;
          tbl_wdata = handle_r;
          res_id    = stk_rdata_r;
        end else begin
          // lookup: a zero handle counts as absent
          res_handle = tbl_rdata_r;
          if (tbl_rdata_r == '0) begin
            res_status = STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_count_r <= '0;
      high_water_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_command;
      id_r     <= in_id;
      handle_r <= in_handle;
    end
    if (res_load) begin
      res_id_r     <= res_id;
      res_handle_r <= res_handle;
      res_status_r <= res_status;
    end
  end

  // handle table, single port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end else if (tbl_re) begin
      tbl_rdata_r <= tbl_mem[tbl_addr];
    end
  end

  // free id stack, single port
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wdata;
    end else if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_id     = res_id_r;
  assign out_result_handle = res_handle_r;
  assign out_status        = res_status_r;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id pool allocator testbench
// Drives add, remove and lookup words through the valid/ready channels with
// random sender gaps and receiver stalls. A shadow copy of the id table, the
// free stack and the high-water count predicts every result word but those of
// fixed rows; each result word is compared field by field against the oldest.
// ----------------------------------------------------------------------------
module testbench;
  import idp_pkg::*;

  localparam int POOL       = 1024;
  localparam int MAX_CYCLES = 600000;
  localparam int DRAIN_WAIT = 20;

  // code 3 has no meaning in the block; the testbench names it to send it
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // one stimulus row; fixed rows carry a result typed in by hand
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [9:0]       id;
    logic [31:0]      h;
    logic             fixed;
    logic [9:0]       rid;
    logic [31:0]      rh;
    status_t          st;
  } row_t;

  // one result word as the block should return it
  typedef struct packed {
    logic [9:0]  rid;
    logic [31:0] rh;
    status_t     st;
  } reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [9:0]          in_id;
  logic [31:0]         in_handle;
  logic                out_valid;
  logic                out_ready;
  logic [9:0]          out_result_id;
  logic [31:0]         out_result_handle;
  logic [STATUS_W-1:0] out_status;

  // shadow state of the allocator
  logic [31:0] shadow_handles [POOL];
  logic [9:0]  shadow_free [POOL];
  int          free_depth = 0;
  int          water_mark = 0;

  reply_t reply_q [$];
  reply_t want_r;
  reply_t got_r;
  row_t   cur_row;
  int     errors = 0;
  int     cycles = 0;
  int     words_sent = 0;
  bit     calm = 1'b0;

  // directed rows: reset state, extremes, lifo reuse, double free, bad ids
  row_t plan [25] = '{
    // empty pool: nothing to find, nothing to remove
    '{CMD_LOOKUP,  10'd0,    32'h0,        1'b1, 10'd0,    32'h0,        STAT_NOT_FOUND},
    '{CMD_REMOVE,  10'd1023, 32'h0,        1'b1, 10'd1023, 32'h0,        STAT_BAD_ID},
    '{CMD_UNKNOWN, 10'd1023, 32'hffffffff, 1'b1, 10'd1023, 32'h0,        STAT_NOT_FOUND},
    // first adds come from the high-water mark, id field ignored
    '{CMD_ADD,     10'd1023, 32'hffffffff, 1'b1, 10'd0,    32'h0,        STAT_OK},
    '{CMD_ADD,     10'd0,    32'h0,        1'b1, 10'd1,    32'h0,        STAT_OK},
    // stored zero handle reads as not found
    '{CMD_LOOKUP,  10'd1,    32'h0,        1'b1, 10'd1,    32'h0,        STAT_NOT_FOUND},
    '{CMD_LOOKUP,  10'd0,    32'h0,        1'b1, 10'd0,    32'hffffffff, STAT_OK},
    '{CMD_ADD,     10'd0,    32'h00000001, 1'b0, 10'd0,    32'h0,        STAT_OK},
    // remove voids the entry, lookup then sees the marker
    '{CMD_REMOVE,  10'd0,    32'h0,        1'b1, 10'd0,    32'h0,        STAT_OK},
    '{CMD_LOOKUP,  10'd0,    32'h0,        1'b1, 10'd0,    32'hdecafbad, STAT_OK},
    '{CMD_ADD,     10'd0,    32'h12345678, 1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_LOOKUP,  10'd0,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    // freed ids come back last in, first out
    '{CMD_REMOVE,  10'd2,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_REMOVE,  10'd1,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_ADD,     10'd0,    32'ha5a5a5a5, 1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_ADD,     10'd0,    32'h5a5a5a5a, 1'b0, 10'd0,    32'h0,        STAT_OK},
    // id equal to the high-water mark
    '{CMD_LOOKUP,  10'd3,    32'h0,        1'b1, 10'd3,    32'h0,        STAT_NOT_FOUND},
    '{CMD_REMOVE,  10'd3,    32'h0,        1'b1, 10'd3,    32'h0,        STAT_BAD_ID},
    // the same id freed twice is handed out twice
    '{CMD_REMOVE,  10'd1,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_REMOVE,  10'd1,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_ADD,     10'd0,    32'h80000000, 1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_ADD,     10'd0,    32'h7fffffff, 1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_LOOKUP,  10'd1,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK},
    '{CMD_UNKNOWN, 10'd0,    32'h0,        1'b1, 10'd0,    32'h0,        STAT_NOT_FOUND},
    '{CMD_LOOKUP,  10'd2,    32'h0,        1'b0, 10'd0,    32'h0,        STAT_OK}
  };

  id_pool_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_id             (in_id),
    .in_handle         (in_handle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_id     (out_result_id),
    .out_result_handle (out_result_handle),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // applies one accepted word to the shadow state and returns its result
  function automatic reply_t predict_reply(input logic [CMD_W-1:0] cmd,
                                           input logic [9:0] id,
                                           input logic [31:0] h);
    reply_t r;
    r.rid = id;
    r.rh  = '0;
    r.st  = STAT_OK;
    case (cmd)
      CMD_ADD: begin
        if (free_depth > 0) begin
          // reuse the most recently freed id
          free_depth--;
          r.rid = shadow_free[free_depth];
          shadow_handles[r.rid] = h;
        end else if (water_mark < POOL) begin
          r.rid = water_mark[9:0];
          shadow_handles[water_mark] = h;
          water_mark++;
        end else begin
          r.rid = '0;
          r.st  = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (id >= water_mark) begin
          r.st = STAT_BAD_ID;
        end else if (free_depth >= POOL) begin
          // free stack full, only reached through repeated removes
          r.st = STAT_FULL;
        end else begin
          shadow_handles[id] = VOID_MARKER[31:0];
          shadow_free[free_depth] = id;
          free_depth++;
        end
      end
      CMD_LOOKUP: begin
        if (id >= water_mark || shadow_handles[id] == 32'h0) r.st = STAT_NOT_FOUND;
        else r.rh = shadow_handles[id];
      end
      default: r.st = STAT_NOT_FOUND;
    endcase
    return r;
  endfunction

  // accepted words go to the predictor, result words are checked in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want_r = predict_reply(in_command, in_id, in_handle);
        if (cur_row.fixed) begin
          want_r.rid = cur_row.rid;
          want_r.rh  = cur_row.rh;
          want_r.st  = cur_row.st;
        end
        reply_q.push_back(want_r);
      end
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result word id %0d handle %h status %0d",
                   $realtime, out_result_id, out_result_handle, out_status);
          errors++;
        end else begin
          got_r = reply_q.pop_front();
          if (out_result_id !== got_r.rid) begin
            $display("%0t: result_id expected %0d actual %0d",
                     $realtime, got_r.rid, out_result_id);
            errors++;
          end
          if (out_result_handle !== got_r.rh) begin
            $display("%0t: result_handle expected %h actual %h",
                     $realtime, got_r.rh, out_result_handle);
            errors++;
          end
          if (out_status !== got_r.st) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, got_r.st, out_status);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stall before each result word, none in calm stretches
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic row_t make_row(input logic [CMD_W-1:0] cmd,
                                    input logic [9:0] id,
                                    input logic [31:0] h);
    row_t w;
    w       = '0;
    w.cmd   = cmd;
    w.id    = id;
    w.h     = h;
    w.fixed = 1'b0;
    return w;
  endfunction

  // mostly ids below the high-water mark so removes and lookups hit entries
  function automatic logic [9:0] pick_id();
    if (water_mark > 0 && $urandom_range(0, 99) < 75)
      return 10'($urandom_range(0, water_mark - 1));
    return 10'($urandom_range(0, POOL - 1));
  endfunction

  // handle mix: zero, all ones, the void marker itself, else random
  function automatic logic [31:0] pick_handle();
    int dice;
    dice = $urandom_range(0, 99);
    if (dice < 10) return 32'h0;
    if (dice < 15) return 32'hffffffff;
    if (dice < 20) return VOID_MARKER[31:0];
    return $urandom();
  endfunction

  // sender: called and returning at a falling edge; every fourth stretch of
  // 64 words runs with no gaps on either side
  task automatic send_word(input row_t w);
    int gap;
    calm = ((words_sent / 64) % 4) == 3;
    gap  = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row = w;
    in_valid   <= 1'b1;
    in_command <= w.cmd;
    in_id      <= w.id;
    in_handle  <= w.h;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // sender holds off until every predicted word has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic mix_words(input int count);
    int n;
    int dice;
    logic [CMD_W-1:0] c;
    for (n = 0; n < count; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 40) c = CMD_ADD;
      else if (dice < 65) c = CMD_REMOVE;
      else if (dice < 95) c = CMD_LOOKUP;
      else c = CMD_UNKNOWN;
      send_word(make_row(c, pick_id(), pick_handle()));
    end
  endtask

  initial begin
    int k;
    in_valid   = 1'b0;
    in_command = CMD_ADD;
    in_id      = '0;
    in_handle  = '0;
    cur_row    = '0;
    rst_n      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (k = 0; k < 25; k++) send_word(plan[k]);
    drain_replies();

    // random mix while the pool is still partly used
    mix_words(150);
    drain_replies();

    // fill the pool up to the top, then try a few more adds
    while (water_mark < POOL || free_depth != 0) begin
      if ($urandom_range(0, 19) == 0) send_word(make_row(CMD_LOOKUP, pick_id(), 32'h0));
      else send_word(make_row(CMD_ADD, pick_id(), pick_handle()));
    end
    repeat (3) send_word(make_row(CMD_ADD, pick_id(), pick_handle()));

    // random mix again, starting from a full pool
    mix_words(200);

    drain_replies();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/idp_pkg.sv
rtl/id_pool_allocator.sv
dv/testbench.sv
